[rtl/aima_pkg.sv]
// Shared helper functions for the interleaved converter moving-average block.
package aima_pkg;

  // Bits needed to index n items; never less than one.
  function automatic int bits_for(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

[rtl/aima_slot_seq.sv]
// Slot counter, shared ring position and air history position.
module aima_slot_seq
  import aima_pkg::*;
#(
  parameter int NUM_CHANNELS = 4,
  parameter int WINDOW_LOG2  = 6,
  parameter int CH_W         = bits_for(NUM_CHANNELS - 1),
  parameter int SLOT_W       = bits_for(2 * (NUM_CHANNELS - 1))
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  output logic                   is_air,
  output logic [CH_W-1:0]        chan,
  output logic [WINDOW_LOG2-1:0] ring_pos,
  output logic [WINDOW_LOG2-1:0] air_idx,
  output logic [SLOT_W-1:0]      next_slot
);

  localparam int FILT      = NUM_CHANNELS - 1;
  localparam int LAST_SLOT = 2 * FILT - 1;

  logic [SLOT_W-1:0]      slot;
  logic [WINDOW_LOG2-1:0] ring_position;
  logic [WINDOW_LOG2-1:0] air_position;
  logic [SLOT_W-1:0]      chan_raw;
  logic                   wrap;

  assign is_air   = slot[0];
  assign chan_raw = slot >> 1;
  assign wrap     = (slot >= SLOT_W'(LAST_SLOT));
  assign ring_pos = ring_position;
  assign air_idx  = air_position;

  always_comb begin
    // clamp a channel past the last filtered one
    if (chan_raw >= SLOT_W'(FILT)) begin
      chan = CH_W'(FILT - 1);
    end else begin
      chan = CH_W'(chan_raw);
    end
    next_slot = wrap ? '0 : slot + SLOT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot          <= '0;
      ring_position <= '0;
      air_position  <= '0;
    end else if (step) begin
      slot <= next_slot;
      if (wrap) begin
        ring_position <= ring_position + WINDOW_LOG2'(1);
      end
      if (is_air) begin
        air_position <= air_position + WINDOW_LOG2'(1);
      end
    end
  end

endmodule

[rtl/aima_hist_ram.sv]
// Sample history memory with per-entry valid bits; unwritten entries read as zero.
module aima_hist_ram
  import aima_pkg::*;
#(
  parameter int DEPTH  = 192,
  parameter int DATA_W = 10,
  parameter int ADDR_W = bits_for(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [DATA_W-1:0] rd_q;
  logic              rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

[rtl/aima_sum_bank.sv]
// Running sums of the filtered channels and the averaged output.
module aima_sum_bank
  import aima_pkg::*;
#(
  parameter int FILT        = 3,
  parameter int WINDOW_LOG2 = 6,
  parameter int SAMPLE_BITS = 10,
  parameter int CH_W        = bits_for(FILT)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   update,
  input  logic [CH_W-1:0]        chan,
  input  logic [SAMPLE_BITS-1:0] old_sample,
  input  logic [SAMPLE_BITS-1:0] new_sample,
  output logic [SAMPLE_BITS-1:0] filtered
);

  localparam int SUM_W = SAMPLE_BITS + WINDOW_LOG2;

  logic [SUM_W-1:0] sums [FILT];
  logic [SUM_W-1:0] sum_next;

  // wraps modulo 2^SUM_W, as the sum is kept
  assign sum_next = sums[chan] - SUM_W'(old_sample) + SUM_W'(new_sample);
  assign filtered = sum_next[SUM_W-1:WINDOW_LOG2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FILT; i++) begin
        sums[i] <= '0;
      end
    end else if (update) begin
      sums[chan] <= sum_next;
    end
  end

endmodule

[rtl/adc_interleaved_moving_average.sv]
// Top level: interleaved converter sample sorter with per-channel moving average.
//
// Takes one converter sample per request, one request per clock. On
// acceptance the input stage issues the registered read of the history
// memory; the result stage then updates the running sum, writes the
// sample back and loads the output register. A stalled output holds
// both stages; a new request is still taken while the input stage
// can move on. Odd slots are the air channel (raw value plus air history
// index), even slots are filtered channel slot/2 with a 2^WINDOW_LOG2-sample
// average. The history memory has a valid bit per entry, cleared by reset,
// so no clearing pass is needed.
module adc_interleaved_moving_average
  import aima_pkg::*;
#(
  parameter int NUM_CHANNELS = 4,
  parameter int WINDOW_LOG2  = 6,
  parameter int SAMPLE_BITS  = 10,
  localparam int FILT        = NUM_CHANNELS - 1,
  localparam int CH_W        = bits_for(FILT),
  localparam int SLOT_W      = bits_for(2 * FILT),
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_BITS    = CH_W + 2 * SAMPLE_BITS + WINDOW_LOG2 + SLOT_W,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sample
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // channel, raw_value, filtered,
                                                 // air_index, next_slot
  output logic [0:0]             m_axis_tuser    // is_air
);

  localparam int DEPTH  = FILT * (1 << WINDOW_LOG2);
  localparam int ADDR_W = bits_for(DEPTH);

  // sequencer view of the current slot
  logic                   seq_is_air;
  logic [CH_W-1:0]        seq_chan;
  logic [WINDOW_LOG2-1:0] seq_ring_pos;
  logic [WINDOW_LOG2-1:0] seq_air_idx;
  logic [SLOT_W-1:0]      seq_next_slot;

  logic                   in_accept;
  logic                   s1_adv;
  logic [ADDR_W-1:0]      rd_addr;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SAMPLE_BITS-1:0] filt_value;

  // input stage
  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic                   s1_is_air;
  logic [CH_W-1:0]        s1_chan;
  logic [ADDR_W-1:0]      s1_addr;
  logic [WINDOW_LOG2-1:0] s1_air_idx;
  logic [SLOT_W-1:0]      s1_next_slot;

  // result stage
  logic                   out_valid;
  logic                   out_is_air;
  logic [CH_W-1:0]        out_chan;
  logic [SAMPLE_BITS-1:0] out_raw;
  logic [SAMPLE_BITS-1:0] out_filt;
  logic [WINDOW_LOG2-1:0] out_air_idx;
  logic [SLOT_W-1:0]      out_next_slot;

  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign rd_addr       = ADDR_W'({seq_chan, seq_ring_pos});

  aima_slot_seq #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .WINDOW_LOG2  (WINDOW_LOG2),
    .CH_W         (CH_W),
    .SLOT_W       (SLOT_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (in_accept),
    .is_air    (seq_is_air),
    .chan      (seq_chan),
    .ring_pos  (seq_ring_pos),
    .air_idx   (seq_air_idx),
    .next_slot (seq_next_slot)
  );

  aima_hist_ram #(
    .DEPTH  (DEPTH),
    .DATA_W (SAMPLE_BITS),
    .ADDR_W (ADDR_W)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (old_sample),
    .wr_en   (s1_adv && !s1_is_air),
    .wr_addr (s1_addr),
    .wr_data (s1_sample)
  );

  aima_sum_bank #(
    .FILT        (FILT),
    .WINDOW_LOG2 (WINDOW_LOG2),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CH_W        (CH_W)
  ) u_sums (
    .clk        (clk),
    .rst        (rst),
    .update     (s1_adv && !s1_is_air),
    .chan       (s1_chan),
    .old_sample (old_sample),
    .new_sample (s1_sample),
    .filtered   (filt_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample    <= s_axis_tdata[SAMPLE_BITS-1:0];
      s1_is_air    <= seq_is_air;
      s1_chan      <= seq_is_air ? '0 : seq_chan;
      s1_addr      <= rd_addr;
      s1_air_idx   <= seq_is_air ? seq_air_idx : '0;
      s1_next_slot <= seq_next_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_is_air    <= s1_is_air;
      out_chan      <= s1_chan;
      out_raw       <= s1_sample;
      out_filt      <= s1_is_air ? '0 : filt_value;
      out_air_idx   <= s1_air_idx;
      out_next_slot <= s1_next_slot;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_is_air;
  assign m_axis_tdata  = OUT_TDATA_W'({out_next_slot, out_air_idx, out_filt, out_raw, out_chan});

endmodule

[verif/testbench.sv]
// Self-checking testbench for the interleaved converter moving-average block.

typedef struct packed {
  logic       is_air;
  logic [1:0] channel;
  logic [9:0] raw_value;
  logic [9:0] filtered;
  logic [5:0] air_index;
  logic [2:0] next_slot;
} slot_result_t;

// Tracks slot sequencing and per-channel averages; holds pending results.
class slot_filter_tracker;
  localparam int LAST_SLOT = 5;

  logic [2:0]   slot;
  logic [5:0]   ring_pos;
  logic [5:0]   air_pos;
  logic [9:0]   history [3][64];
  logic [15:0]  sums [3];
  slot_result_t expected_results [$];
  int           errors;
  int           air_checked;
  int           filt_checked;
  int           ring_wraps;

  function new();
    slot = '0;
    ring_pos = '0;
    air_pos = '0;
    foreach (history[c, i]) history[c][i] = '0;
    foreach (sums[c]) sums[c] = '0;
    errors = 0;
    air_checked = 0;
    filt_checked = 0;
    ring_wraps = 0;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  // Accepted request: advance the model and queue what the block must return.
  function void note_sample(logic [15:0] word);
    slot_result_t r;
    logic [9:0]   smp;
    logic [1:0]   ch;
    logic [15:0]  sum;
    smp = word[9:0];  // padding bits above the sample are ignored
    r = '0;
    r.raw_value = smp;
    if (slot[0]) begin
      r.is_air = 1'b1;
      r.air_index = air_pos;
      air_pos = air_pos + 6'd1;
    end else begin
      ch = slot[2:1];
      sum = sums[ch] - {6'd0, history[ch][ring_pos]} + {6'd0, smp};
      history[ch][ring_pos] = smp;
      sums[ch] = sum;
      r.channel = ch;
      r.filtered = sum[15:6];
    end
    if (slot < LAST_SLOT) begin
      slot = slot + 3'd1;
    end else begin
      slot = '0;
      ring_pos = ring_pos + 6'd1;
      if (ring_pos == 0) ring_wraps++;
    end
    r.next_slot = slot;
    expected_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [9:0] exp_v, logic [9:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_result(logic [31:0] data, logic [0:0] user);
    slot_result_t e;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual tdata=%h tuser=%b",
               $time, data, user);
      errors++;
      return;
    end
    e = expected_results.pop_front();
    compare_field("is_air", {9'd0, e.is_air}, {9'd0, user[0]});
    compare_field("channel", {8'd0, e.channel}, {8'd0, data[1:0]});
    compare_field("raw_value", e.raw_value, data[11:2]);
    compare_field("filtered", e.filtered, data[21:12]);
    compare_field("air_index", {4'd0, e.air_index}, {4'd0, data[27:22]});
    compare_field("next_slot", {7'd0, e.next_slot}, {7'd0, data[30:28]});
    if (e.is_air) air_checked++;
    else filt_checked++;
  endfunction
endclass

module testbench;
  localparam int LONG_HOLD  = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASES     = 10;
  localparam int PHASE_LEN  = 195;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  slot_filter_tracker score = new();

  int  rx_idle_pct;
  int  tx_idle_pct;
  bit  hold_off_req;
  int  stall_left;
  int  quiet_cycles;

  adc_interleaved_moving_average dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_sample(input logic [15:0] word);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk); while (!s_axis_tready);
    score.note_sample(word);
  endtask

  task automatic input_gap(input int n);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (tx_idle_pct != 0 && $urandom_range(0, 9) < tx_idle_pct)
      input_gap($urandom_range(1, 9));
  endtask

  task automatic drain();
    while (score.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample(int style, logic [9:0] level);
    logic [15:0] w;
    case (style)
      0: w = {6'd0, 10'($urandom_range(0, 1023))};
      1: w = ($urandom_range(0, 1) != 0) ? 16'h03FF : 16'h0000;
      default: w = ($urandom_range(0, 7) == 0) ? {6'd0, 10'($urandom_range(0, 1023))}
                                                : {6'd0, level};
    endcase
    // occasional junk in the padding bits above the sample
    if ($urandom_range(0, 15) == 0) w[15:10] = 6'($urandom);
    return w;
  endfunction

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 9) < rx_idle_pct) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      score.check_result(m_axis_tdata, m_axis_tuser);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no request moved for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] directed [$];
    logic [9:0]  level;
    int          style;

    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    rx_idle_pct = 0;
    tx_idle_pct = 0;
    hold_off_req = 1'b0;
    stall_left = 0;
    quiet_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Extremes, alternating bit patterns, and samples with padding bits set.
    directed = '{16'h0000, 16'h03FF, 16'h03FF, 16'h0000, 16'h0001, 16'h0200,
                 16'h0155, 16'h02AA, 16'h02AA, 16'h0155, 16'h03FF, 16'h03FF,
                 16'hFC00, 16'hFFFF, 16'hA955, 16'h56AA, 16'h03FE, 16'h0001,
                 16'h03FF, 16'h03FF, 16'h03FF, 16'h03FF, 16'h03FF, 16'h03FF};
    foreach (directed[i]) send_sample(directed[i]);

    // Long output hold-off while the input keeps offering: block must back up.
    hold_off_req = 1'b1;
    repeat (24) send_sample(pick_sample(0, '0));
    input_gap(1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      style = p % 3;
      level = 10'($urandom_range(0, 1023));
      if (p == 4 || p == PHASES - 1) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = $urandom_range(1, 4);
        rx_idle_pct = $urandom_range(1, 4);
      end
      for (int i = 0; i < PHASE_LEN; i++) begin
        send_sample(pick_sample(style, level));
        maybe_gap();
      end
      if (p == 5) begin
        input_gap(1);
        drain();
      end
    end

    input_gap(1);
    drain();
    repeat (10) @(posedge clk);
    if (score.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, score.pending());
      score.errors++;
    end

    $display("Checked %0d air and %0d filtered results; filter ring wrapped %0d times.",
             score.air_checked, score.filt_checked, score.ring_wraps);
    if (score.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
